// ===== src/spq_pkg.sv =====
// Package with the item types, request and status codes for the sorted priority queue.
package spq_pkg;

    // Request kinds carried in the op field of an input item.
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP_MIN = 2'd1,
        OP_POP_MAX = 2'd2
    } t_op;

    // Status codes returned with every result item.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One request.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic signed [31:0] popped_value;
        logic               popped_valid;
        logic [1:0]         status;
        logic [4:0]         held_count;
    } t_out_item;

    // Command broadcast to every cell of a chain.
    typedef struct packed {
        logic               push;
        logic               shift;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

// ===== src/spq_cell.sv =====
// One cell of a sorted chain: holds a value and inserts or shifts with its neighbors.
module spq_cell #(
    parameter bit DESCEND = 1'b0
) (
    input  logic                       i_clk,
    input  spq_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_occ,
    input  logic                       i_left_keep,
    input  logic signed [31:0]         i_left_value,
    input  logic signed [31:0]         i_right_value,
    output logic                       o_keep,
    output logic signed [31:0]         o_value
);
    import spq_pkg::*;

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               w_ahead;

    // The cell stays put on a push when its value sorts ahead of the new one.
    // Equal values move behind the pushed item.
    assign w_ahead = DESCEND ? (r_value > i_ctl.value) : (r_value < i_ctl.value);
    assign o_keep  = i_occ && w_ahead;
    assign o_value = r_value;

    // Next value: keep, take the new item, take the left neighbor, or the right on a shift.
    always_comb begin
        n_value = r_value;
        if (i_ctl.push) begin
            if (o_keep) begin
                n_value = r_value;
            end else if (i_left_keep) begin
                n_value = i_ctl.value;
            end else begin
                n_value = i_left_value;
            end
        end else if (i_ctl.shift) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue built from two chains of sorted cells.
//
// Input channel (i_in_valid, o_in_ready, i_in_item) carries requests: push a
// signed value, pop the minimum or pop the maximum. Every accepted item yields
// exactly one result item on the output channel (o_out_valid, i_out_ready,
// o_out_item): the popped value with its valid flag, a status and the count
// held after the request.
// The store is two rows of DEPTH cells, one ascending and one descending, both
// holding the same values from cell 0 upward. The minimum sits in cell 0 of
// the ascending row and the maximum in cell 0 of the descending row, so every
// request is served by local compares and neighbor moves.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle while the receiver takes results; the output register is
// the only stage, so o_in_ready is high when it is empty or being emptied in
// the same cycle.
// When the receiver stalls, the result holds and no new item is accepted.
// Reset empties the queue (count to zero) and drops any pending result; cell
// contents need no clearing since cells above the count are never read.
// A push on a full queue or a pop on an empty one changes nothing and
// returns an error status.
module sorted_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_item o_out_item
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_push;
    logic               w_pop_min;
    logic               w_pop_max;
    logic [CW+4:0]      w_count_wide;
    t_cell_ctl          w_ctl_asc;
    t_cell_ctl          w_ctl_desc;

    logic               w_occ      [DEPTH];
    logic               w_asc_keep [DEPTH];
    logic signed [31:0] w_asc_val  [DEPTH];
    logic               w_desc_keep[DEPTH];
    logic signed [31:0] w_desc_val [DEPTH];

    // Handshake and request decode.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_push      = w_accept && (i_in_item.op == OP_PUSH) && !w_full;
    assign w_pop_min   = w_accept && (i_in_item.op == OP_POP_MIN) && !w_empty;
    assign w_pop_max   = w_accept && (i_in_item.op == OP_POP_MAX) && !w_empty;

    // A pop on one row shifts it down; the other row just loses its last cell.
    assign w_ctl_asc.push   = w_push;
    assign w_ctl_asc.shift  = w_pop_min;
    assign w_ctl_asc.value  = i_in_item.value;
    assign w_ctl_desc.push  = w_push;
    assign w_ctl_desc.shift = w_pop_max;
    assign w_ctl_desc.value = i_in_item.value;

    // The two rows of cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_occ[g] = (r_count > CW'(g));

        spq_cell #(
            .DESCEND (1'b0)
        ) u_asc (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl_asc),
            .i_occ         (w_occ[g]),
            .i_left_keep   ((g == 0) ? 1'b1 : w_asc_keep[(g == 0) ? 0 : g - 1]),
            .i_left_value  (w_asc_val[(g == 0) ? 0 : g - 1]),
            .i_right_value (w_asc_val[(g == DEPTH - 1) ? g : g + 1]),
            .o_keep        (w_asc_keep[g]),
            .o_value       (w_asc_val[g])
        );

        spq_cell #(
            .DESCEND (1'b1)
        ) u_desc (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl_desc),
            .i_occ         (w_occ[g]),
            .i_left_keep   ((g == 0) ? 1'b1 : w_desc_keep[(g == 0) ? 0 : g - 1]),
            .i_left_value  (w_desc_val[(g == 0) ? 0 : g - 1]),
            .i_right_value (w_desc_val[(g == DEPTH - 1) ? g : g + 1]),
            .o_keep        (w_desc_keep[g]),
            .o_value       (w_desc_val[g])
        );
    end

    // Count update.
    always_comb begin
        n_count = r_count;
        if (w_push) begin
            n_count = r_count + CW'(1);
        end else if (w_pop_min || w_pop_max) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_count_wide = {5'd0, n_count};

    // Result item for the accepted request.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_accept) begin
            n_out_valid             = 1'b1;
            n_out.popped_value      = '0;
            n_out.popped_valid      = w_pop_min || w_pop_max;
            n_out.status            = ST_OK;
            n_out.held_count        = w_count_wide[4:0];
            if (w_pop_min) begin
                n_out.popped_value = w_asc_val[0];
            end else if (w_pop_max) begin
                n_out.popped_value = w_desc_val[0];
            end
            if ((i_in_item.op == OP_PUSH) && w_full) begin
                n_out.status = ST_FULL;
            end else if (((i_in_item.op == OP_POP_MIN) || (i_in_item.op == OP_POP_MAX))
                         && w_empty) begin
                n_out.status = ST_EMPTY;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count above capacity");

    // A push on a full queue leaves the count unchanged.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_item.op == OP_PUSH) && w_full) |=> (r_count == $past(r_count)))
        else $error("push on full queue changed the count");

    // Both rows agree: the minimum never sorts above the maximum.
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_empty |-> (w_asc_val[0] <= w_desc_val[0]))
        else $error("minimum above maximum");

    // Every accepted item produces a pending result.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    // A popped value only comes with an ok status.
    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.popped_valid) |-> (r_out.status == ST_OK))
        else $error("popped value with error status");
`endif

endmodule

// ===== test/spq_checker.sv =====
// Checker that predicts and compares every result item of the sorted priority queue.
`timescale 1ns / 100ps

module spq_checker #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  spq_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  spq_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_outstanding,
    output int                 o_requests,
    output int                 o_results,
    output int                 o_full_refusals,
    output int                 o_empty_refusals
);

    import spq_pkg::*;

    // Shadow of the queue contents, ascending, and results still to arrive.
    logic signed [31:0] shadow_values[$];
    t_out_item          awaited_results[$];

    int fail_count     = 0;
    int outstanding    = 0;
    int requests       = 0;
    int results        = 0;
    int full_refusals  = 0;
    int empty_refusals = 0;

    assign o_fail_count     = fail_count;
    assign o_outstanding    = outstanding;
    assign o_requests       = requests;
    assign o_results        = results;
    assign o_full_refusals  = full_refusals;
    assign o_empty_refusals = empty_refusals;

    // Applies one request to the shadow queue and returns the result it should give.
    function automatic t_out_item apply_request(input t_in_item req);
        t_out_item          res;
        logic signed [31:0] v;
        int                 pos;
        res        = '0;
        res.status = ST_OK;
        v          = req.value;
        case (req.op)
            OP_PUSH: begin
                if (shadow_values.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // A new value goes ahead of any equal ones.
                    pos = 0;
                    while (pos < shadow_values.size() && shadow_values[pos] < v)
                        pos++;
                    shadow_values.insert(pos, v);
                end
            end
            OP_POP_MIN: begin
                if (shadow_values.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped_value = shadow_values.pop_front();
                    res.popped_valid = 1'b1;
                end
            end
            OP_POP_MAX: begin
                if (shadow_values.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped_value = shadow_values.pop_back();
                    res.popped_valid = 1'b1;
                end
            end
            default: begin
                // The unused request code leaves everything as it is.
            end
        endcase
        res.held_count = 5'(shadow_values.size());
        return res;
    endfunction

    // Counts a failure and reports it.
    task automatic flag_failure(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
        fail_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // Compares one delivered result with the oldest awaited one.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        results++;
        if (awaited_results.size() == 0) begin
            flag_failure("unrequested result, held_count", 0, got.held_count);
            return;
        end
        want = awaited_results.pop_front();
        if (got.popped_value !== want.popped_value)
            flag_failure("popped_value", want.popped_value, got.popped_value);
        if (got.popped_valid !== want.popped_valid)
            flag_failure("popped_valid", want.popped_valid, got.popped_valid);
        if (got.status !== want.status)
            flag_failure("status", want.status, got.status);
        if (got.held_count !== want.held_count)
            flag_failure("held_count", want.held_count, got.held_count);
        if (want.status == ST_FULL)
            full_refusals++;
        if (want.status == ST_EMPTY)
            empty_refusals++;
    endtask

    // A result leaving at this edge belongs to an earlier request, so check it first.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_values.delete();
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result(i_out_item);
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(apply_request(i_in_item));
                requests++;
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

// ===== test/tb_sorted_priority_queue_core.sv =====
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_core;

    import spq_pkg::*;

    localparam int         DEPTH        = 16;
    localparam int         TOTAL_ITEMS  = 650;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         LONG_HOLD    = 60;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    int fail_count;
    int outstanding;
    int requests;
    int results;
    int full_refusals;
    int empty_refusals;

    // Stimulus bookkeeping: items sent, fill level and gap-free phases.
    int sent    = 0;
    int level   = 0;
    bit no_gaps = 1'b0;

    sorted_priority_queue_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item)
    );

    spq_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_item       (in_item),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .i_out_item      (o_out_item),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_requests      (requests),
        .o_results       (results),
        .o_full_refusals (full_refusals),
        .o_empty_refusals(empty_refusals)
    );

    // Clock with a 10 ns period.
    initial begin
        forever #5 clk = ~clk;
    end

    // Values lean toward a narrow band for duplicates and toward the extremes.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1:    return 32'($urandom_range(0, 8)) - 32'd4;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7fff_ffff;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Mixed request kinds, mostly pushes and pops with a few unused codes.
    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return OP_PUSH;
        else if (r < 14)
            return OP_POP_MIN;
        else if (r < 19)
            return OP_POP_MAX;
        return OP_UNUSED;
    endfunction

    // Offers one item after a random gap and waits until it is accepted.
    task automatic send_request(input logic [1:0] op, input logic signed [31:0] value);
        t_in_item item;
        int       gap;
        item.op    = op;
        item.value = value;
        gap        = no_gaps ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!o_in_ready)
            @(posedge clk);
        sent++;
        case (op)
            OP_PUSH:                if (level < DEPTH) level++;
            OP_POP_MIN, OP_POP_MAX: if (level > 0) level--;
            default: ;
        endcase
    endtask

    // Result side: a random hold-off per item, and two long stalls to back up the input.
    initial begin : result_sink
        int hold;
        int taken;
        taken = 0;
        wait (rst_n);
        forever begin
            if (taken == 150 || taken == 420)
                hold = LONG_HOLD;
            else
                hold = no_gaps ? 0 : $urandom_range(0, 3);
            repeat (hold) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!o_out_valid)
                @(posedge clk);
            taken++;
        end
    end

    // Ends the run when no item moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
        $display("tb_sorted_priority_queue_core NOT OK");
        $finish;
    end

    // Reset, directed requests, random sequences, then the verdict.
    initial begin : stimulus
        int extra;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Refusals and the unused code on an empty queue.
        send_request(OP_POP_MIN, 32'h0000_0000);
        send_request(OP_POP_MAX, 32'hffff_ffff);
        send_request(OP_UNUSED, 32'h1234_5678);
        // Extremes, zero, minus one and a duplicate.
        send_request(OP_PUSH, 32'h7fff_ffff);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_PUSH, 32'hffff_ffff);
        send_request(OP_PUSH, 32'h0000_0001);
        send_request(OP_UNUSED, 32'h0000_0000);
        send_request(OP_POP_MAX, 32'h0000_0000);
        send_request(OP_POP_MIN, 32'h0000_0000);
        send_request(OP_POP_MIN, 32'h0000_0000);
        send_request(OP_POP_MAX, 32'h0000_0000);
        send_request(OP_POP_MIN, 32'h0000_0000);
        // Pop maximum with a single value held.
        send_request(OP_POP_MAX, 32'h0000_0000);
        send_request(OP_POP_MAX, 32'h0000_0000);
        send_request(OP_PUSH, 32'h5555_5555);
        send_request(OP_POP_MAX, 32'h0000_0000);
        send_request(OP_PUSH, 32'haaaa_aaaa);
        send_request(OP_POP_MIN, 32'h0000_0000);

        // Random part: fill-and-drain runs mixed with free request streams.
        while (sent < TOTAL_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                extra = $urandom_range(0, 2);
                while (level < DEPTH)
                    send_request(OP_PUSH, pick_value());
                repeat (extra) send_request(OP_PUSH, pick_value());
                while (level > 0)
                    send_request(($urandom_range(0, 1) != 0) ? OP_POP_MAX : OP_POP_MIN,
                                 pick_value());
                repeat (extra) send_request(OP_POP_MIN, pick_value());
            end else begin
                repeat ($urandom_range(10, 30)) send_request(pick_op(), pick_value());
            end
        end
        no_gaps = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain the remaining results, then allow a few cycles of settling.
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d requests and checked %0d results.", requests, results);
        $display("Full-queue pushes: %0d, empty-queue pops: %0d.",
                 full_refusals, empty_refusals);
        if (fail_count == 0)
            $display("tb_sorted_priority_queue_core OK");
        else
            $display("tb_sorted_priority_queue_core NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_core.sv
test/spq_checker.sv
test/tb_sorted_priority_queue_core.sv
